// ===== rtl/stft_pkg.sv =====
// stft_pkg: shared types, constants and coefficient tables for the stft log spectrogram
// depends on nothing; used by stft_log_unit and stft_log_spectrogram
`default_nettype none

package stft_pkg;

    localparam int WINDOW    = 32;
    localparam int LAST_BIN  = WINDOW / 2;
    localparam logic [5:0] HOP_RESET = 6'd16;
    localparam logic [31:0] LN2_Q30  = 32'd744261118;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               end_of_signal;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        frame_number;
        logic [4:0]         bin_number;
        logic signed [15:0] log_magnitude;
        logic               last_bin;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WIN,
        S_DFT,
        S_LOG,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        L_IDLE,
        L_SHIFT,
        L_SQ_RE,
        L_SQ_IM,
        L_NORM,
        L_FRAC,
        L_SCALE,
        L_ROUND
    } t_log_state;

    // cos(2*pi*idx/32) in q15 for idx 0..8
    function automatic logic [15:0] cos_base(logic [3:0] idx);
        logic [15:0] v;
        case (idx)
            4'd0:    v = 16'd32768;
            4'd1:    v = 16'd32138;
            4'd2:    v = 16'd30274;
            4'd3:    v = 16'd27246;
            4'd4:    v = 16'd23170;
            4'd5:    v = 16'd18205;
            4'd6:    v = 16'd12540;
            4'd7:    v = 16'd6393;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // cos(2*pi*m/32) in q15, quadrant folded
    function automatic logic signed [16:0] twid_cos(logic [4:0] m);
        logic [3:0]         r;
        logic [3:0]         rr;
        logic signed [16:0] c;
        logic signed [16:0] res;
        r  = {1'b0, m[2:0]};
        rr = 4'd8 - r;
        case (m[4:3])
            2'd0:    begin c = $signed({1'b0, cos_base(r)});  res = c;  end
            2'd1:    begin c = $signed({1'b0, cos_base(rr)}); res = -c; end
            2'd2:    begin c = $signed({1'b0, cos_base(r)});  res = -c; end
            default: begin c = $signed({1'b0, cos_base(rr)}); res = c;  end
        endcase
        return res;
    endfunction

    // sin(2*pi*m/32) = cos(2*pi*(m-8)/32)
    function automatic logic signed [16:0] twid_sin(logic [4:0] m);
        return twid_cos(m - 5'd8);
    endfunction

    // hamming window in q15, symmetric about the middle
    function automatic logic [15:0] win_coef(logic [4:0] i);
        logic [3:0]  j;
        logic [15:0] v;
        j = i[4] ? ~i[3:0] : i[3:0];
        case (j)
            4'd0:    v = 16'd2621;
            4'd1:    v = 16'd2930;
            4'd2:    v = 16'd3843;
            4'd3:    v = 16'd5323;
            4'd4:    v = 16'd7310;
            4'd5:    v = 16'd9721;
            4'd6:    v = 16'd12460;
            4'd7:    v = 16'd15412;
            4'd8:    v = 16'd18458;
            4'd9:    v = 16'd21473;
            4'd10:   v = 16'd24333;
            4'd11:   v = 16'd26921;
            4'd12:   v = 16'd29132;
            4'd13:   v = 16'd30874;
            4'd14:   v = 16'd32077;
            default: v = 16'd32691;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/stft_log_spectrogram.sv =====
// stft_log_spectrogram: hamming-windowed 32-point dft with log magnitude output
// depends on stft_pkg and stft_log_unit
`default_nettype none

// usage
// - input channel: one sample request per accept (valid/ready); end_of_signal marks
//   the final sample. ready is high only while no frame is being worked on
// - output channel: bins 0..16 of each frame, in order, as valid/ready requests;
//   last_bin flags the final bin caused by one input sample
// - a sample that completes no frame leaves the block idle and ready
// - a frame is first windowed, each sample through the shared multiplier; then per
//   bin it runs a dft of 32 terms (a cos and a sin product per term) and a pass
//   through the log unit (normalize, 16 squaring steps, scale); windowing and
//   the dft share the one multiplier
// - a stalled receiver holds the current bin in the output register and the
//   sequencer waits; no request is dropped
// - reset returns hop_size to 16, clears the sample and frame counters and the stop
//   flag; the sample ring and work memory need no clearing
// - after the end-of-signal sample, further requests are accepted and dropped
// - the user writes hop_size via i_cfg_we/i_cfg_data only while idle; not enforced
module stft_log_spectrogram (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire stft_pkg::t_in_item  i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output stft_pkg::t_out_item      o_out,
    input  wire logic                i_cfg_we,
    input  wire logic [5:0]          i_cfg_data
);

    stft_pkg::t_state r_state, n_state;

    // configuration and stream counters
    logic [5:0]  r_hop;
    logic [31:0] r_seen, n_seen;
    logic [31:0] r_next_end, n_next_end;
    logic [15:0] r_frames, n_frames;
    logic        r_stopped, n_stopped;

    // frame control
    logic        r_f2_pend, n_f2_pend;
    logic [5:0]  r_avail, n_avail;
    logic [5:0]  r_avail2, n_avail2;
    logic        r_last, n_last;
    logic [4:0]  r_first, n_first;
    logic [4:0]  r_i, n_i;
    logic [1:0]  r_ph, n_ph;
    logic [4:0]  r_k, n_k;
    logic signed [51:0] r_re, n_re, r_im, n_im;
    logic        r_log_go, n_log_go;
    stft_pkg::t_out_item r_out, n_out;
    logic        r_out_valid, n_out_valid;

    // memories
    logic [15:0] ring [32];
    logic [31:0] work [32];
    logic [15:0] r_ring_q;
    logic [31:0] r_work_q;
    logic [4:0]  ring_addr;

    // shared multiplier
    logic signed [31:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [48:0] r_prod;

    logic        log_done;
    logic signed [15:0] log_res;

    // request decode
    logic        in_acc;
    logic [5:0]  hop_eff;
    logic [31:0] seen_inc, ne_inc, behind;
    logic        full;
    logic [5:0]  avail_eos;
    logic        f2;
    logic [9:0]  km;
    logic [4:0]  m;
    logic        out_acc;

    assign o_in_ready = (r_state == stft_pkg::S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready && !r_stopped;
    assign out_acc    = r_out_valid && i_out_ready;

    // out-of-range hop folds into 1..32
    assign hop_eff  = (r_hop == 6'd0) ? 6'd1 : (r_hop > 6'd32) ? 6'd32 : r_hop;
    assign seen_inc = r_seen + 32'd1;
    assign full     = (seen_inc == r_next_end);
    assign ne_inc   = full ? r_next_end + {26'd0, hop_eff} : r_next_end;
    assign behind   = ne_inc - seen_inc;
    assign avail_eos = (behind <= 32'd32) ? 6'd32 - behind[5:0] : 6'd0;
    assign f2       = i_in.end_of_signal && (avail_eos >= hop_eff);

    // twiddle index (k*n) mod 32
    assign km = {5'd0, r_k} * {5'd0, r_i};
    assign m  = km[4:0];

    assign ring_addr = r_first + r_i;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            ring[r_seen[4:0]] <= i_in.sample;
        end
        r_ring_q <= ring[ring_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == stft_pkg::S_WIN && r_ph == 2'd2) begin
            work[r_i] <= r_prod[31:0];
        end
        r_work_q <= work[r_i];
    end

    // operand select: windowing or dft terms
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            stft_pkg::S_WIN: begin
                // samples past the end of a short frame read as zero
                mul_a = ({1'b0, r_i} < r_avail) ? {{16{r_ring_q[15]}}, r_ring_q} : '0;
                mul_b = $signed({1'b0, stft_pkg::win_coef(r_i)});
            end
            stft_pkg::S_DFT: begin
                mul_a = $signed(r_work_q);
                mul_b = (r_ph == 2'd1) ? stft_pkg::twid_cos(m) : stft_pkg::twid_sin(m);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    stft_log_unit u_log (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_log_go),
        .i_re     (r_re),
        .i_im     (r_im),
        .o_done   (log_done),
        .o_result (log_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stft_pkg::S_IDLE:
                if (in_acc && (full || f2)) n_state = stft_pkg::S_WIN;
            stft_pkg::S_WIN:
                if (r_ph == 2'd2 && r_i == 5'd31) n_state = stft_pkg::S_DFT;
            stft_pkg::S_DFT:
                if (r_ph == 2'd3 && r_i == 5'd31) n_state = stft_pkg::S_LOG;
            stft_pkg::S_LOG:
                if (log_done) n_state = stft_pkg::S_OUT;
            stft_pkg::S_OUT:
                if (out_acc) begin
                    if (r_k != 5'(stft_pkg::LAST_BIN)) n_state = stft_pkg::S_DFT;
                    else if (r_f2_pend)                 n_state = stft_pkg::S_WIN;
                    else                                n_state = stft_pkg::S_IDLE;
                end
            default: n_state = stft_pkg::S_IDLE;
        endcase
    end

    // datapath and control registers
    always_comb begin
        n_seen = r_seen; n_next_end = r_next_end; n_frames = r_frames;
        n_stopped = r_stopped; n_f2_pend = r_f2_pend; n_avail = r_avail;
        n_avail2 = r_avail2; n_last = r_last; n_first = r_first; n_i = r_i;
        n_ph = r_ph; n_k = r_k; n_re = r_re; n_im = r_im; n_log_go = 1'b0;
        n_out = r_out; n_out_valid = r_out_valid;
        unique case (r_state)
            stft_pkg::S_IDLE:
                if (in_acc) begin
                    n_seen     = seen_inc;
                    n_next_end = ne_inc;
                    if (i_in.end_of_signal) n_stopped = 1'b1;
                    n_i  = '0;
                    n_ph = '0;
                    n_k  = '0;
                    n_re = '0;
                    n_im = '0;
                    if (full) begin
                        n_avail   = 6'd32;
                        n_first   = seen_inc[4:0];
                        n_f2_pend = f2;
                        n_avail2  = avail_eos;
                        n_last    = !f2;
                    end else begin
                        n_avail   = avail_eos;
                        n_first   = seen_inc[4:0] - avail_eos[4:0];
                        n_f2_pend = 1'b0;
                        n_last    = 1'b1;
                    end
                end
            stft_pkg::S_WIN: begin
                // read ring, multiply by window, write work memory
                if (r_ph == 2'd2) begin
                    n_ph = '0;
                    n_i  = r_i + 5'd1;
                end else begin
                    n_ph = r_ph + 2'd1;
                end
            end
            stft_pkg::S_DFT: begin
                // read term, multiply cos, accumulate re / multiply sin, accumulate im
                if (r_ph == 2'd2) n_re = r_re + 52'(r_prod);
                if (r_ph == 2'd3) begin
                    n_im = r_im - 52'(r_prod);
                    n_i  = r_i + 5'd1;
                    if (r_i == 5'd31) n_log_go = 1'b1;
                end
                n_ph = r_ph + 2'd1;
            end
            stft_pkg::S_LOG:
                if (log_done) begin
                    n_out.frame_number  = r_frames;
                    n_out.bin_number    = r_k;
                    n_out.log_magnitude = log_res;
                    n_out.last_bin      = (r_k == 5'(stft_pkg::LAST_BIN)) && r_last;
                    n_out_valid         = 1'b1;
                end
            stft_pkg::S_OUT:
                if (out_acc) begin
                    n_out_valid = 1'b0;
                    n_i  = '0;
                    n_ph = '0;
                    n_re = '0;
                    n_im = '0;
                    if (r_k != 5'(stft_pkg::LAST_BIN)) begin
                        n_k = r_k + 5'd1;
                    end else begin
                        n_k      = '0;
                        n_frames = r_frames + 16'd1;
                        if (r_f2_pend) begin
                            // zero-padded tail frame after a full one
                            n_f2_pend = 1'b0;
                            n_avail   = r_avail2;
                            n_first   = r_seen[4:0] - r_avail2[4:0];
                            n_last    = 1'b1;
                        end
                    end
                end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stft_pkg::S_IDLE;
            r_hop       <= stft_pkg::HOP_RESET;
            r_seen      <= '0;
            r_next_end  <= 32'(stft_pkg::WINDOW);
            r_frames    <= '0;
            r_stopped   <= 1'b0;
            r_f2_pend   <= 1'b0;
            r_log_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) r_hop <= i_cfg_data;
            r_seen      <= n_seen;
            r_next_end  <= n_next_end;
            r_frames    <= n_frames;
            r_stopped   <= n_stopped;
            r_f2_pend   <= n_f2_pend;
            r_log_go    <= n_log_go;
            r_out_valid <= n_out_valid;
        end
        r_avail  <= n_avail;
        r_avail2 <= n_avail2;
        r_last   <= n_last;
        r_first  <= n_first;
        r_i      <= n_i;
        r_ph     <= n_ph;
        r_k      <= n_k;
        r_re     <= n_re;
        r_im     <= n_im;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ===== rtl/stft_log_unit.sv =====
// stft_log_unit: iterative 0.5*ln(re^2+im^2) in signed q8 with one 32x32 multiplier
// depends on stft_pkg
`default_nettype none

module stft_log_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [51:0] i_re,
    input  wire logic signed [51:0] i_im,
    output logic                    o_done,
    output logic signed [15:0]      o_result
);

    stft_pkg::t_log_state r_state, n_state;
    logic [51:0] r_ar, n_ar, r_ai, n_ai;
    logic [4:0]  r_sh, n_sh;
    logic [62:0] r_p, n_p;
    logic [5:0]  r_e, n_e;
    logic [31:0] r_y, n_y;
    logic [15:0] r_frac, n_frac;
    logic [3:0]  r_cnt, n_cnt;
    logic [63:0] r_m, n_m;
    logic        r_neg, n_neg;
    logic signed [15:0] r_res, n_res;
    logic        r_done, n_done;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [51:0] abs_re, abs_im;
    logic signed [7:0]  ei;
    logic signed [23:0] t_val;
    logic [23:0] t_mag;
    logic [24:0] q;
    logic [63:0] rounded;

    assign abs_re = i_re[51] ? 52'(-i_re) : 52'(i_re);
    assign abs_im = i_im[51] ? 52'(-i_im) : 52'(i_im);
    assign ei     = $signed({2'b00, r_e}) + $signed({2'b00, r_sh, 1'b0}) - 8'sd60;
    assign t_val  = {ei, r_frac};
    assign t_mag  = t_val[23] ? 24'(-t_val) : 24'(t_val);
    assign rounded = r_m + (64'd1 << 38);
    assign q       = rounded[63:39];

    always_comb begin
        mul_a = r_y;
        mul_b = r_y;
        case (r_state)
            stft_pkg::L_SQ_RE: begin mul_a = r_ar[31:0]; mul_b = r_ar[31:0]; end
            stft_pkg::L_SQ_IM: begin mul_a = r_ai[31:0]; mul_b = r_ai[31:0]; end
            stft_pkg::L_SCALE: begin mul_a = {8'd0, t_mag}; mul_b = stft_pkg::LN2_Q30; end
            default: ;
        endcase
    end

    assign prod = mul_a * mul_b;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stft_pkg::L_IDLE:
                if (i_start && (i_re != '0 || i_im != '0)) n_state = stft_pkg::L_SHIFT;
            stft_pkg::L_SHIFT:
                if (r_ar[51:31] == '0 && r_ai[51:31] == '0) n_state = stft_pkg::L_SQ_RE;
            stft_pkg::L_SQ_RE: n_state = stft_pkg::L_SQ_IM;
            stft_pkg::L_SQ_IM: n_state = stft_pkg::L_NORM;
            stft_pkg::L_NORM:
                if (r_p[62:32] == '0 && r_p[31]) n_state = stft_pkg::L_FRAC;
            stft_pkg::L_FRAC:
                if (r_cnt == 4'd15) n_state = stft_pkg::L_SCALE;
            stft_pkg::L_SCALE: n_state = stft_pkg::L_ROUND;
            stft_pkg::L_ROUND: n_state = stft_pkg::L_IDLE;
            default: n_state = stft_pkg::L_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        logic [32:0] s;
        n_ar = r_ar; n_ai = r_ai; n_sh = r_sh; n_p = r_p; n_e = r_e; n_y = r_y;
        n_frac = r_frac; n_cnt = r_cnt; n_m = r_m; n_neg = r_neg; n_res = r_res;
        n_done = 1'b0;
        s = prod[63:31];
        unique case (r_state)
            stft_pkg::L_IDLE:
                if (i_start) begin
                    n_ar = abs_re;
                    n_ai = abs_im;
                    n_sh = '0;
                    if (i_re == '0 && i_im == '0) begin
                        n_res  = -16'sd32768;
                        n_done = 1'b1;
                    end
                end
            stft_pkg::L_SHIFT:
                if (r_ar[51:31] != '0 || r_ai[51:31] != '0) begin
                    n_ar = r_ar >> 1;
                    n_ai = r_ai >> 1;
                    n_sh = r_sh + 5'd1;
                end
            stft_pkg::L_SQ_RE: n_p = prod[62:0];
            stft_pkg::L_SQ_IM: begin
                n_p = r_p + prod[62:0];
                n_e = 6'd31;
            end
            stft_pkg::L_NORM:
                if (r_p[62:32] != '0) begin
                    n_p = r_p >> 1;
                    n_e = r_e + 6'd1;
                end else if (!r_p[31]) begin
                    n_p = r_p << 1;
                    n_e = r_e - 6'd1;
                end else begin
                    n_y    = r_p[31:0];
                    n_cnt  = '0;
                    n_frac = '0;
                end
            stft_pkg::L_FRAC: begin
                if (s[32]) begin
                    n_y    = s[32:1];
                    n_frac = {r_frac[14:0], 1'b1};
                end else begin
                    n_y    = s[31:0];
                    n_frac = {r_frac[14:0], 1'b0};
                end
                n_cnt = r_cnt + 4'd1;
            end
            stft_pkg::L_SCALE: begin
                n_m   = prod;
                n_neg = t_val[23];
            end
            stft_pkg::L_ROUND: begin
                if (!r_neg && q > 25'd32767)      n_res = 16'sd32767;
                else if (r_neg && q > 25'd32768)  n_res = -16'sd32768;
                else if (r_neg)                   n_res = 16'(-$signed(q));
                else                              n_res = $signed(q[15:0]);
                n_done = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stft_pkg::L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_ar <= n_ar; r_ai <= n_ai; r_sh <= n_sh; r_p <= n_p; r_e <= n_e;
        r_y <= n_y; r_frac <= n_frac; r_cnt <= n_cnt; r_m <= n_m; r_neg <= n_neg;
        r_res <= n_res;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

`default_nettype wire
